/* rtl/efc_pkg.sv */
// shared types and constants of the envelope follower compressor
`timescale 1ns / 1ps
`default_nettype none

package efc_pkg;

  // default widths of the audio path
  localparam int unsigned SAMPLE_WIDTH_DEF  = 16;
  localparam int unsigned ENV_FRAC_BITS_DEF = 16;

  // register field widths
  localparam int unsigned THR_W     = 15;
  localparam int unsigned GRIT_W    = 13;
  localparam int unsigned ST_W      = 23;
  localparam int unsigned CFG_W     = 23;
  localparam int unsigned CFG_IDX_W = 2;

  // register reset values
  localparam int unsigned THR_RESET  = 10240;
  localparam int unsigned GRIT_RESET = 0;
  localparam int unsigned ST_RESET   = 89478;

  // grit is q0.12
  localparam int unsigned GRIT_ONE = 4096;

  // follower rates in 1/s, scaled by 4096
  localparam int unsigned RATE_W    = 26;
  localparam int unsigned RISE_BASE = 4096000;
  localparam int unsigned RISE_GAIN = 10000;
  localparam int unsigned FALL_BASE = 40960;
  localparam int unsigned FALL_GAIN = 1000;

  // rate times sample time, and the q0.32 coefficient taken from it
  localparam int unsigned RATE_PROD_W = RATE_W + ST_W;
  localparam int unsigned COEF_SHIFT  = 12;
  localparam int unsigned COEF_W      = 32;

  // multiplier operand / quotient register and step counter
  localparam int unsigned MPL_W = 32;
  localparam int unsigned CNT_W = 6;

  // width of the shared adder at the default sizes
  localparam int unsigned ALU_W_DEF = SAMPLE_WIDTH_DEF + ENV_FRAC_BITS_DEF + COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_GRIT_KNOB   = 2'd1,
    CFG_SAMPLE_TIME = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

/* rtl/efc_in_if.sv */
// input channel: audio sample and grit control voltage
`timescale 1ns / 1ps
`default_nettype none

interface efc_in_if #(
  parameter int unsigned SAMPLE_WIDTH = efc_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] audio_in;
  logic signed [SAMPLE_WIDTH-1:0] grit_cv;

  modport source (output valid, output audio_in, output grit_cv, input ready);
  modport sink   (input valid, input audio_in, input grit_cv, output ready);
endinterface

`default_nettype wire

/* rtl/efc_out_if.sv */
// output channel: compressed audio sample
`timescale 1ns / 1ps
`default_nettype none

interface efc_out_if #(
  parameter int unsigned SAMPLE_WIDTH = efc_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] audio_out;

  modport source (output valid, output audio_out, input ready);
  modport sink   (input valid, input audio_out, output ready);
endinterface

`default_nettype wire

/* rtl/efc_addsub.sv */
// shared add / subtract unit with carry out (carry set on subtract means no borrow)
`timescale 1ns / 1ps
`default_nettype none

module efc_addsub #(
  parameter int unsigned WIDTH = efc_pkg::ALU_W_DEF
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] res_o,
  output logic             carry_o
);
  logic [WIDTH:0] sum;

  assign sum     = {1'b0, a_i} + {1'b0, b_i ^ {WIDTH{sub_i}}} + {{WIDTH{1'b0}}, sub_i};
  assign res_o   = sum[WIDTH-1:0];
  assign carry_o = sum[WIDTH];
endmodule

`default_nettype wire

/* rtl/envelope_follower_compressor.sv */
// top level: feedforward envelope compressor on one shared adder under a sequencer
// sequence: prepare, rate, coefficient multiply, step multiply, update, numerator multiply, divide;
//   a saturated coefficient skips the step multiply, an envelope already on target goes straight to the numerator
// one word at a time, since the shift-add multiplies and the restoring divide all run
//   through the one adder; not ready while a word is at work
// reset: envelope cleared, registers to threshold 10240, grit knob 0, sample time 89478
`timescale 1ns / 1ps
`default_nettype none

module envelope_follower_compressor #(
  parameter int unsigned SAMPLE_WIDTH  = efc_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned ENV_FRAC_BITS = efc_pkg::ENV_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [efc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [efc_pkg::CFG_W-1:0]     cfg_data_i,
  efc_in_if.sink                        in_i,
  efc_out_if.source                     out_o
);
  import efc_pkg::*;

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned EF    = ENV_FRAC_BITS;
  // envelope holds up to 2^(SW-1+EF)
  localparam int unsigned ENV_W = SW + EF;
  // widest value through the adder: diff times coefficient
  localparam int unsigned UW    = ENV_W + COEF_W;
  // grit sum: knob plus twice the cv, signed
  localparam int unsigned GW    = SW + 3;
  localparam int unsigned TQ_W  = THR_W + EF;

  localparam logic [ENV_W-1:0] ENV_MAX = {1'b1, {(ENV_W-1){1'b0}}};

  // one-hot sequencer states
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_PREP  = 10'b00_0000_0010,
    S_RATE  = 10'b00_0000_0100,
    S_MCOEF = 10'b00_0000_1000,
    S_COEF  = 10'b00_0001_0000,
    S_MSTEP = 10'b00_0010_0000,
    S_UPD   = 10'b00_0100_0000,
    S_MNUM  = 10'b00_1000_0000,
    S_DSET  = 10'b01_0000_0000,
    S_DIV   = 10'b10_0000_0000
  } state_e;

  // configuration registers
  logic [THR_W-1:0]  thr_q, thr_d;
  logic [GRIT_W-1:0] knob_q, knob_d;
  logic [ST_W-1:0]   st_q, st_d;

  // control
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              fin_q, fin_d;      // result waits for the output register
  logic [ENV_W-1:0]  env_q, env_d;

  // datapath
  logic [UW-1:0]     acc_q, acc_d;      // product accumulator / division remainder
  logic [UW-1:0]     mcand_q, mcand_d;  // multiplicand / shifted divisor
  logic [MPL_W-1:0]  mplier_q, mplier_d;// multiplier bits / quotient
  logic [ENV_W-1:0]  diff_q, diff_d;
  logic [SW-1:0]     ax_q, ax_d;
  logic              neg_q, neg_d;
  logic              rise_q, rise_d;
  logic [GRIT_W-1:0] grit_q, grit_d;
  logic [SW-1:0]     out_data_q, out_data_d;

  // shared adder
  logic [UW-1:0]     alu_a, alu_b, alu_res;
  logic              alu_sub, alu_carry;

  logic              in_fire;
  logic signed [GW-1:0] grit_sum;
  logic [GRIT_W-1:0] grit_in;
  logic [SW-1:0]     ax_in;
  logic [ENV_W-1:0]  target;
  logic [THR_W-1:0]  t_eff;
  logic [TQ_W-1:0]   tq;
  logic [RATE_W-1:0] rate;
  logic [ENV_W-1:0]  step;
  logic              coef_sat;
  logic              mul_state;
  logic [SW-1:0]     q_mag;

  assign in_fire = in_i.valid && in_i.ready;

  // grit = knob + 2*cv, clamped to 0..one
  assign grit_sum = signed'(GW'(knob_q)) + (GW'(in_i.grit_cv) <<< 1);

  always_comb begin
    priority if (grit_sum < 0) begin
      grit_in = '0;
    end else if (grit_sum > signed'(GW'(GRIT_ONE))) begin
      grit_in = GRIT_W'(GRIT_ONE);
    end else begin
      grit_in = grit_sum[GRIT_W-1:0];
    end
  end

  // magnitude of the sample; the most negative code maps to 2^(SW-1)
  assign ax_in  = in_i.audio_in[SW-1] ? (SW'(0) - in_i.audio_in) : in_i.audio_in;
  assign target = {ax_q, {EF{1'b0}}};

  // zero threshold counts as one lsb
  assign t_eff = (thr_q == '0) ? THR_W'(1) : thr_q;
  assign tq    = {t_eff, {EF{1'b0}}};

  // follower rate for the current direction, from the registered grit
  assign rate = rise_q ? (RATE_W'(RISE_BASE) + RATE_W'(grit_q) * RATE_W'(RISE_GAIN))
                       : (RATE_W'(FALL_BASE) + RATE_W'(grit_q) * RATE_W'(FALL_GAIN));

  // coefficient = (rate * st) >> 12, saturates at one
  assign coef_sat = |acc_q[RATE_PROD_W-1:COEF_SHIFT+COEF_W];
  // step = (diff * coef) >> 32
  assign step     = acc_q[COEF_W +: ENV_W];
  assign q_mag    = mplier_q[SW-1:0];

  assign mul_state = (state_q == S_MCOEF) || (state_q == S_MSTEP) || (state_q == S_MNUM);

  // operand select for the shared adder
  always_comb begin
    alu_a   = acc_q;
    alu_b   = mcand_q;
    alu_sub = 1'b0;
    unique case (state_q)
      S_PREP: begin
        alu_a   = UW'(target);
        alu_b   = UW'(env_q);
        alu_sub = 1'b1;
      end
      S_RATE: begin
        alu_a   = rise_q ? UW'(target) : UW'(env_q);
        alu_b   = rise_q ? UW'(env_q) : UW'(target);
        alu_sub = 1'b1;
      end
      S_UPD: begin
        alu_a   = UW'(env_q);
        alu_b   = UW'(step);
        alu_sub = !rise_q;
      end
      S_DSET: begin
        alu_a   = UW'(env_q);
        alu_b   = UW'(tq);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  efc_addsub #(
    .WIDTH (UW)
  ) u_addsub (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  // sequencer and datapath next values
  always_comb begin
    thr_d       = thr_q;
    knob_d      = knob_q;
    st_d        = st_q;
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    fin_d       = fin_q;
    env_d       = env_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    diff_d      = diff_q;
    ax_d        = ax_q;
    neg_d       = neg_q;
    rise_d      = rise_q;
    grit_d      = grit_q;
    out_data_d  = out_data_q;

    // register writes, index beyond the list ignored
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD:   thr_d  = cfg_data_i[THR_W-1:0];
        CFG_GRIT_KNOB:   knob_d = cfg_data_i[GRIT_W-1:0];
        CFG_SAMPLE_TIME: st_d   = cfg_data_i[ST_W-1:0];
        default: begin
        end
      endcase
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // finished quotient goes to the output register once it is free
    if (fin_q && (!out_valid_q || out_o.ready)) begin
      out_data_d  = neg_q ? (SW'(0) - q_mag) : q_mag;
      out_valid_d = 1'b1;
      fin_d       = 1'b0;
      state_d     = S_IDLE;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          ax_d    = ax_in;
          neg_d   = in_i.audio_in[SW-1];
          grit_d  = grit_in;
          state_d = S_PREP;
        end
      end

      S_PREP: begin
        if (alu_res == '0) begin
          // envelope already on target: straight to the numerator
          acc_d    = '0;
          mcand_d  = UW'(ax_q);
          mplier_d = MPL_W'(t_eff);
          cnt_d    = CNT_W'(THR_W);
          state_d  = S_MNUM;
        end else begin
          rise_d  = alu_carry;
          state_d = S_RATE;
        end
      end

      S_RATE: begin
        diff_d   = alu_res[ENV_W-1:0];
        acc_d    = '0;
        mcand_d  = UW'(rate);
        mplier_d = MPL_W'(st_q);
        cnt_d    = CNT_W'(ST_W);
        state_d  = S_MCOEF;
      end

      S_MCOEF, S_MSTEP, S_MNUM: begin
        // one shift-add step
        if (mplier_q[0]) begin
          acc_d = alu_res;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          unique case (state_q)
            S_MCOEF: state_d = S_COEF;
            S_MSTEP: state_d = S_UPD;
            default: state_d = S_DSET;
          endcase
        end
      end

      S_COEF: begin
        if (coef_sat) begin
          // coefficient of one: step equals the whole difference
          env_d    = target;
          acc_d    = '0;
          mcand_d  = UW'(ax_q);
          mplier_d = MPL_W'(t_eff);
          cnt_d    = CNT_W'(THR_W);
          state_d  = S_MNUM;
        end else begin
          acc_d    = '0;
          mcand_d  = UW'(diff_q);
          mplier_d = acc_q[COEF_SHIFT +: COEF_W];
          cnt_d    = CNT_W'(COEF_W);
          state_d  = S_MSTEP;
        end
      end

      S_UPD: begin
        // vanishing step snaps to the target
        env_d    = (step == '0) ? target : alu_res[ENV_W-1:0];
        acc_d    = '0;
        mcand_d  = UW'(ax_q);
        mplier_d = MPL_W'(t_eff);
        cnt_d    = CNT_W'(THR_W);
        state_d  = S_MNUM;
      end

      S_DSET: begin
        // numerator = ax * t << frac, divisor = max(env, tq) aligned to the top quotient bit
        acc_d    = acc_q << EF;
        mcand_d  = (alu_carry ? UW'(env_q) : UW'(tq)) << (SW - 1);
        mplier_d = '0;
        cnt_d    = CNT_W'(SW);
        state_d  = S_DIV;
      end

      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (alu_carry) begin
          acc_d = alu_res;
        end
        mplier_d = {mplier_q[MPL_W-2:0], alu_carry};
        mcand_d  = mcand_q >> 1;
        cnt_d    = cnt_q - CNT_W'(1);
        // a result already waiting is not finished a second time
        if (!fin_q && (cnt_q == CNT_W'(1))) begin
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // hold off new work while a result still waits for the output register
    if (fin_d) begin
      state_d = S_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THR_W'(THR_RESET);
      knob_q      <= GRIT_W'(GRIT_RESET);
      st_q        <= ST_W'(ST_RESET);
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      fin_q       <= 1'b0;
      env_q       <= '0;
    end else begin
      thr_q       <= thr_d;
      knob_q      <= knob_d;
      st_q        <= st_d;
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      fin_q       <= fin_d;
      env_q       <= env_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= fin_q ? acc_q : acc_d;
    mcand_q    <= fin_q ? mcand_q : mcand_d;
    mplier_q   <= fin_q ? mplier_q : mplier_d;
    diff_q     <= diff_d;
    ax_q       <= ax_d;
    neg_q      <= neg_d;
    rise_q     <= rise_d;
    grit_q     <= grit_d;
    out_data_q <= out_data_d;
  end

  assign in_i.ready      = (state_q == S_IDLE) && !fin_q;
  assign out_o.valid     = out_valid_q;
  assign out_o.audio_out = out_data_q;

  // envelope never passes the largest target
  assert property (@(posedge clk_i) disable iff (!rst_ni) env_q <= ENV_MAX)
    else $error("envelope above full scale");

  // remainder stays below twice the shifted divisor through the divide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_DIV && !fin_q) |-> ({1'b0, acc_q} < {mcand_q, 1'b0}))
    else $error("division remainder out of range");

  // iterating states always have steps left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (mul_state || (state_q == S_DIV && !fin_q)) |-> (cnt_q != '0))
    else $error("step counter ran out");

  // a new result only comes from a finished divide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> $past(fin_q))
    else $error("result without finished divide");

  // an accepted word starts the sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_fire |=> (state_q == S_PREP))
    else $error("accepted word did not start the sequence");

endmodule

`default_nettype wire

/* tb/envelope_follower_compressor_tb.sv */
// testbench of the envelope follower compressor: randomized words checked against a predictor
`timescale 1ns / 1ps

class compressor_scoreboard;
  // predictor copy of the registers and of the follower state
  logic [efc_pkg::THR_W-1:0]  thr;
  logic [efc_pkg::GRIT_W-1:0] knob;
  logic [efc_pkg::ST_W-1:0]   st;
  longint unsigned            envelope;
  logic signed [efc_pkg::SAMPLE_WIDTH_DEF-1:0] expected_q[$];
  int unsigned errors;

  function new();
    thr      = efc_pkg::THR_RESET;
    knob     = efc_pkg::GRIT_RESET;
    st       = efc_pkg::ST_RESET;
    envelope = 0;
    errors   = 0;
  endfunction

  function void write_reg(logic [efc_pkg::CFG_IDX_W-1:0] idx, logic [efc_pkg::CFG_W-1:0] data);
    case (idx)
      efc_pkg::CFG_THRESHOLD:   thr  = data[efc_pkg::THR_W-1:0];
      efc_pkg::CFG_GRIT_KNOB:   knob = data[efc_pkg::GRIT_W-1:0];
      efc_pkg::CFG_SAMPLE_TIME: st   = data[efc_pkg::ST_W-1:0];
      default: ;
    endcase
  endfunction

  // q0.32 follower coefficient, saturated at one
  function longint unsigned follower_coef(longint unsigned rate);
    longint unsigned c;
    c = (rate * longint'(st)) >> efc_pkg::COEF_SHIFT;
    return (c > (64'd1 << 32)) ? (64'd1 << 32) : c;
  endfunction

  // floor(d * c / 2^32) split so nothing overflows
  function longint unsigned scaled_step(longint unsigned d, longint unsigned c);
    return (((d >> 16) * c) + (((d & 64'hFFFF) * c) >> 16)) >> 16;
  endfunction

  function void note_input(logic signed [efc_pkg::SAMPLE_WIDTH_DEF-1:0] audio,
                           logic signed [efc_pkg::SAMPLE_WIDTH_DEF-1:0] cv);
    longint g;
    longint unsigned grit, ax, target, step, t, tq, den, q, res;
    g = longint'(knob) + 2 * longint'(cv);
    if (g < 0) g = 0;
    if (g > longint'(efc_pkg::GRIT_ONE)) g = longint'(efc_pkg::GRIT_ONE);
    grit = g;
    if (audio < 0) ax = -longint'(audio);
    else ax = longint'(audio);
    target = ax << efc_pkg::ENV_FRAC_BITS_DEF;
    if (target > envelope) begin
      step = scaled_step(target - envelope,
                         follower_coef(efc_pkg::RISE_BASE + efc_pkg::RISE_GAIN * grit));
      envelope = (step == 0) ? target : envelope + step;
    end else if (target < envelope) begin
      step = scaled_step(envelope - target,
                         follower_coef(efc_pkg::FALL_BASE + efc_pkg::FALL_GAIN * grit));
      envelope = (step == 0) ? target : envelope - step;
    end
    t   = (thr == 0) ? 64'd1 : longint'(thr);
    tq  = t << efc_pkg::ENV_FRAC_BITS_DEF;
    den = (envelope > tq) ? envelope : tq;
    q   = (ax * tq) / den;
    res = (audio < 0) ? (64'd0 - q) : q;
    expected_q.push_back(res[efc_pkg::SAMPLE_WIDTH_DEF-1:0]);
  endfunction

  function void check_result(logic signed [efc_pkg::SAMPLE_WIDTH_DEF-1:0] got);
    logic signed [efc_pkg::SAMPLE_WIDTH_DEF-1:0] exp_word;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: audio_out with no word pending, expected none actual %0d", $time, got);
      return;
    end
    exp_word = expected_q.pop_front();
    if (got !== exp_word) begin
      errors++;
      $display("%0t: audio_out mismatch, expected %0d actual %0d", $time, exp_word, got);
    end
  endfunction
endclass

module envelope_follower_compressor_tb;
  localparam int unsigned SW              = efc_pkg::SAMPLE_WIDTH_DEF;
  localparam int unsigned FB              = efc_pkg::ENV_FRAC_BITS_DEF;
  localparam int unsigned ITEMS_PER_PHASE = 95;
  localparam int unsigned DIR_COUNT       = 15;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_GAP         = 190;
  localparam int unsigned END_CYCLES      = 120;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  // index past the register list, the block ignores it
  localparam logic [efc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [efc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [efc_pkg::CFG_W-1:0]     cfg_data;

  efc_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
  efc_out_if #(.SAMPLE_WIDTH(SW)) out_if ();

  compressor_scoreboard sb;

  // idle chance in percent, shared by both sides; zero gives a calm stretch
  int unsigned idle_pct     = 26;
  // asks the receiver process for one long hold-off
  bit          hold_off_req = 1'b0;
  // burst state of the random audio source
  int          burst_level  = 0;
  int          burst_left   = 0;
  int unsigned quiet_cycles = 0;

  // directed words: field extremes, full-scale swings, grit cv at both rails
  int dir_audio [DIR_COUNT] = '{0, 32767, 32767, -32768, -32768, 0, 1, -1, 32767, 0,
                                -32768, 12000, -12000, 0, 0};
  int dir_cv    [DIR_COUNT] = '{0, 0, 32767, -32768, 32767, -32768, 0, 0, 2048, 2048,
                                -1, 1000, -1000, 32767, 0};

  envelope_follower_compressor #(
    .SAMPLE_WIDTH (SW),
    .ENV_FRAC_BITS(FB)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one word, with a random gap ahead of it; the word is noted once accepted
  task automatic send_word(input logic signed [SW-1:0] audio, input logic signed [SW-1:0] cv);
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(MAX_GAP, 1);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.audio_in <= audio;
    in_if.grit_cv  <= cv;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(audio, cv);
  endtask

  // random words: mostly bursts of a held level so the follower rises, settles and
  // decays, mixed with raw noise and rail values
  task automatic run_random(input int unsigned n);
    int a_int, cv_int, mag, pick;
    for (int unsigned i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        // silent bursts let the envelope fall toward zero
        burst_level = ($urandom_range(4) == 0) ? 0 : $urandom_range(32768, 0);
        burst_left  = $urandom_range(40, 1);
      end
      burst_left--;
      pick = $urandom_range(99);
      if (pick < 65) begin
        mag   = burst_level - $urandom_range(burst_level / 8, 0);
        a_int = $urandom_range(1) ? -mag : mag;
        if (a_int > 32767) a_int = 32767;
      end else if (pick < 85) begin
        a_int = $signed(16'($urandom));
      end else begin
        case ($urandom_range(4))
          0: a_int = 0;
          1: a_int = 32767;
          2: a_int = -32768;
          3: a_int = 1;
          default: a_int = -1;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 70) cv_int = $urandom_range(4096, 0) - 2048;
      else if (pick < 90) cv_int = $signed(16'($urandom));
      else cv_int = $urandom_range(1) ? 32767 : -32768;
      send_word(a_int[SW-1:0], cv_int[SW-1:0]);
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // one write per edge, the ignored index first, then the three registers
  task automatic set_config(input logic [efc_pkg::CFG_W-1:0] thr,
                            input logic [efc_pkg::CFG_W-1:0] knob,
                            input logic [efc_pkg::CFG_W-1:0] st);
    logic [efc_pkg::CFG_IDX_W-1:0] idx_list [4];
    logic [efc_pkg::CFG_W-1:0]     data_list [4];
    idx_list  = '{CFG_UNUSED, efc_pkg::CFG_THRESHOLD, efc_pkg::CFG_GRIT_KNOB,
                  efc_pkg::CFG_SAMPLE_TIME};
    data_list = '{23'($urandom), thr, knob, st};
    for (int k = 0; k < 4; k++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx_list[k];
      cfg_data <= data_list[k];
      @(posedge clk);
      sb.write_reg(idx_list[k], data_list[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_if.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.audio_out);
  end

  // watchdog: ends the run once no word moves on either side for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.audio_in = '0;
    in_if.grit_cv  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: directed words, then random
    for (int i = 0; i < DIR_COUNT; i++) send_word(dir_audio[i][SW-1:0], dir_cv[i][SW-1:0]);
    run_random(ITEMS_PER_PHASE);
    wait_drain();

    // zero threshold counts as one lsb, zero sample time makes the envelope follow exactly;
    // the receiver holds off long enough midway for the block to stall its input
    set_config(0, 0, 0);
    run_random(20);
    hold_off_req = 1'b1;
    run_random(ITEMS_PER_PHASE - 20);
    wait_drain();

    // register maxima: knob above one clamps, huge sample time saturates the coefficient
    set_config(32767, 8191, 23'h7FFFFF);
    run_random(ITEMS_PER_PHASE);
    wait_drain();

    // top of the documented ranges, sender pauses midway until all results are back
    set_config(20480, 4096, 4294967);
    run_random(45);
    wait_drain();
    run_random(ITEMS_PER_PHASE - 45);
    wait_drain();

    // slowest follower, steps vanish and snap to the target
    set_config(1, 0, 1);
    run_random(ITEMS_PER_PHASE);
    wait_drain();

    // calm stretch: no idling on either side
    idle_pct = 0;
    set_config(10240, 2048, 89478);
    run_random(ITEMS_PER_PHASE);
    wait_drain();
    idle_pct = 26;

    set_config(512, 0, 22369);
    run_random(ITEMS_PER_PHASE);
    wait_drain();

    // raw random register words, wider than the fields
    for (int p = 0; p < 5; p++) begin
      set_config(23'($urandom), 23'($urandom), 23'($urandom));
      run_random(ITEMS_PER_PHASE);
      wait_drain();
    end

    // random settings in the usual audio range
    set_config($urandom_range(20480, 256), $urandom_range(4096, 0),
               $urandom_range(200000, 20000));
    run_random(ITEMS_PER_PHASE);
    wait_drain();

    // let any stray result show up before the verdict
    repeat (END_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
